[rtl/core/tcb_pkg.sv]
// shared types and constants for the text console buffer
package tcb_pkg;

    localparam int          TCB_ROWS     = 25;
    localparam int          TCB_COLS     = 80;
    localparam logic [15:0] BLANK_RESET  = 16'h2007;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_BACK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } tcb_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } tcb_state_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEXT_ROW,
        CUR_COL0,
        CUR_BACK,
        CUR_HOME
    } tcb_cur_op_t;

    typedef struct packed {
        logic        load;
        tcb_cur_op_t cur_op;
        logic        wr_char;
        logic        wr_back;
        logic        rd_cell;
        logic        sweep;
        logic        copy;
        logic        fill_reset;
        logic        out_load;
    } tcb_cmd_t;

    typedef struct packed {
        tcb_op_t op;
        logic    newline;
        logic    row_zero;
        logic    row_last;
        logic    col_zero;
        logic    col_last;
        logic    rd_in_range;
        logic    sweep_last;
        logic    out_free;
    } tcb_status_t;

endpackage

[rtl/core/text_console_buffer.sv]
// top level of the text console buffer
// Text console of ROWS x COLS 16-bit cells (character high byte, attribute low byte) with a
// cursor; each accepted word returns one result word carrying the cursor. Put, backspace and
// read are accepted, executed against the cell ram, and their result is loaded into the result
// register once it is free. A put that scrolls and a clear walk the whole cell ram through its
// one read and one write port. After reset the ram is swept to the reset blank cell with
// s_ready low; blank cell writes are taken at any time.
module text_console_buffer
    import tcb_pkg::*;
#(
    parameter int ROWS = TCB_ROWS,
    parameter int COLS = TCB_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_attr,
    input  logic [10:0] s_read_pos,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic [4:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col,
    output logic [10:0] m_cursor_pos,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    tcb_cmd_t    cmd;
    tcb_status_t status;

    tcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcb_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_opcode     (s_opcode),
        .s_char_code  (s_char_code),
        .s_attr       (s_attr),
        .s_read_pos   (s_read_pos),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_char  (m_cell_char),
        .m_cell_attr  (m_cell_attr),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_cursor_pos (m_cursor_pos)
    );

    // ram port is owned by the sweep while it runs
    a_sweep_owns_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> !(cmd.wr_char || cmd.wr_back || cmd.rd_cell))
        else $error("single access during sweep");

    // one word in flight
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while busy");

    // result register never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwritten");

endmodule

[rtl/core/tcb_ram.sv]
// generic single write port, single read port ram with registered read
module tcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/tcb_ctrl.sv]
// control state machine for the text console buffer
module tcb_ctrl
    import tcb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  tcb_status_t status,
    output tcb_cmd_t    cmd
);

    tcb_state_t state_reg;
    tcb_state_t state_next;
    logic       wrap;

    assign wrap = status.newline || status.col_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.op)
                    OP_PUT:   state_next = (wrap && status.row_last) ? ST_SCROLL : ST_DONE;
                    OP_BACK:  state_next = ST_DONE;
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_READ:  state_next = ST_DONE;
                endcase
            end
            ST_SCROLL, ST_CLEAR: begin
                if (status.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        cmd.cur_op = CUR_HOLD;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep      = 1'b1;
                cmd.fill_reset = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                unique case (status.op)
                    OP_PUT: begin
                        cmd.wr_char = !status.newline;
                        if (wrap) begin
                            cmd.cur_op = status.row_last ? CUR_COL0 : CUR_NEXT_ROW;
                        end else begin
                            cmd.cur_op = CUR_ADVANCE;
                        end
                    end
                    OP_BACK: begin
                        if (!(status.row_zero && status.col_zero)) begin
                            cmd.wr_back = 1'b1;
                            cmd.cur_op  = CUR_BACK;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.cur_op = CUR_HOME;
                    end
                    OP_READ: begin
                        cmd.rd_cell = status.rd_in_range;
                    end
                endcase
            end
            ST_SCROLL: begin
                cmd.sweep = 1'b1;
                cmd.copy  = 1'b1;
            end
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd.cur_op = CUR_HOLD;
            end
        endcase
    end

endmodule

[rtl/core/tcb_datapath.sv]
// cursor, cell ram, sweep counter and result register
module tcb_datapath
    import tcb_pkg::*;
#(
    parameter int ROWS = TCB_ROWS,
    parameter int COLS = TCB_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  tcb_cmd_t    cmd,
    output tcb_status_t status,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_attr,
    input  logic [10:0] s_read_pos,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic [4:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col,
    output logic [10:0] m_cursor_pos
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);

    tcb_op_t           op_reg;
    logic [7:0]        char_reg;
    logic [7:0]        attr_reg;
    logic [10:0]       rpos_reg;
    logic [15:0]       blank_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              m_valid_reg;
    logic [15:0]       cell_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ADDR_W-1:0] out_pos_reg;

    logic [ADDR_W-1:0] pos;
    logic              copy_zone;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [15:0]       fill;
    logic [15:0]       cell_next;

    assign pos  = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLS)) + ADDR_W'(col_reg);
    assign fill = cmd.fill_reset ? BLANK_RESET : blank_reg;

    assign status.op          = op_reg;
    assign status.newline     = (char_reg == NEWLINE_CODE);
    assign status.row_zero    = (row_reg == '0);
    assign status.row_last    = (row_reg == ROW_W'(ROWS - 1));
    assign status.col_zero    = (col_reg == '0);
    assign status.col_last    = (col_reg == COL_W'(COLS - 1));
    assign status.rd_in_range = (32'(rpos_reg) < 32'(CELLS));
    assign status.sweep_last  = (cnt_reg == CNT_W'(CELLS));
    assign status.out_free    = !m_valid_reg || m_ready;

    // input word and blank cell register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= tcb_op_t'(s_opcode);
            char_reg <= s_char_code;
            attr_reg <= s_attr;
            rpos_reg <= s_read_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_reg <= BLANK_RESET;
        end else if (cfg_wr_en) begin
            blank_reg <= cfg_wr_data;
        end
    end

    // cursor
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        unique case (cmd.cur_op)
            CUR_HOLD: begin
            end
            CUR_ADVANCE: begin
                col_next = col_reg + COL_W'(1);
            end
            CUR_NEXT_ROW: begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            CUR_COL0: begin
                col_next = '0;
            end
            CUR_BACK: begin
                if (col_reg == '0) begin
                    col_next = COL_W'(COLS - 1);
                    row_next = row_reg - ROW_W'(1);
                end else begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            CUR_HOME: begin
                col_next = '0;
                row_next = '0;
            end
            default: begin
            end
        endcase
    end

    // sweep: read cnt+COLS, write cnt-1 with the word that the previous sweep step read
    assign cnt_next  = status.sweep_last ? '0 : cnt_reg + CNT_W'(1);
    assign copy_zone = (cnt_reg <= CNT_W'(CELLS - COLS));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(rpos_reg);
        wr_en   = 1'b0;
        wr_addr = pos;
        wr_data = {char_reg, attr_reg};
        if (cmd.sweep) begin
            rd_en   = cmd.copy && (cnt_reg < CNT_W'(CELLS - COLS));
            rd_addr = ADDR_W'(cnt_reg + CNT_W'(COLS));
            wr_en   = (cnt_reg != '0);
            wr_addr = ADDR_W'(cnt_reg - CNT_W'(1));
            wr_data = (cmd.copy && copy_zone) ? rd_data : fill;
        end else if (cmd.wr_back) begin
            wr_en   = 1'b1;
            wr_addr = pos - ADDR_W'(1);
            wr_data = blank_reg;
        end else begin
            wr_en   = cmd.wr_char;
            rd_en   = cmd.rd_cell;
        end
    end

    tcb_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cmd.sweep) begin
                cnt_reg <= cnt_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word
    always_comb begin
        if (op_reg != OP_READ) begin
            cell_next = '0;
        end else if (status.rd_in_range) begin
            cell_next = rd_data;
        end else begin
            cell_next = blank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            cell_reg    <= cell_next;
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            out_pos_reg <= pos;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_char  = cell_reg[15:8];
    assign m_cell_attr  = cell_reg[7:0];
    assign m_cursor_row = 5'(out_row_reg);
    assign m_cursor_col = 7'(out_col_reg);
    assign m_cursor_pos = 11'(out_pos_reg);

endmodule
